// File: design/c2p_pkg.sv
// Shared constants, types and the arctangent table of the rectangular-to-polar converter.
`default_nettype none
package c2p_pkg;

  // Fractional bits kept under the datapath coordinates.
  localparam int GUARD = 24;
  // Fractional bits of the angle accumulator, in degrees.
  localparam int ANGLE_FRAC = 24;
  // Width of the angle accumulator: sign, 10 integer bits, ANGLE_FRAC fraction.
  localparam int Z_WIDTH = 35;
  localparam int HALF_TURN = 180;
  localparam int ATAN_ENTRIES = 32;
  localparam int ATAN_IDX_W = $clog2(ATAN_ENTRIES);
  // Inverse CORDIC gain, unsigned Q32.
  localparam logic [63:0] INV_GAIN = 64'd2608131496;
  localparam logic signed [Z_WIDTH-1:0] HALF_Q24 =
    Z_WIDTH'(64'(HALF_TURN) << ANGLE_FRAC);

  // Control that travels with each beat down the cell chain.
  typedef struct packed {
    logic valid;
    logic bypass;
  } flags_t;

  // atan(2^-k) in degrees, ANGLE_FRAC fractional bits.
  function automatic logic signed [Z_WIDTH-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] k);
    logic signed [Z_WIDTH-1:0] r;
    case (k)
      5'd0:  r = Z_WIDTH'(64'd754974720);
      5'd1:  r = Z_WIDTH'(64'd445687602);
      5'd2:  r = Z_WIDTH'(64'd235489088);
      5'd3:  r = Z_WIDTH'(64'd119537938);
      5'd4:  r = Z_WIDTH'(64'd60000934);
      5'd5:  r = Z_WIDTH'(64'd30029717);
      5'd6:  r = Z_WIDTH'(64'd15018523);
      5'd7:  r = Z_WIDTH'(64'd7509720);
      5'd8:  r = Z_WIDTH'(64'd3754917);
      5'd9:  r = Z_WIDTH'(64'd1877466);
      5'd10: r = Z_WIDTH'(64'd938734);
      5'd11: r = Z_WIDTH'(64'd469367);
      5'd12: r = Z_WIDTH'(64'd234684);
      5'd13: r = Z_WIDTH'(64'd117342);
      5'd14: r = Z_WIDTH'(64'd58671);
      5'd15: r = Z_WIDTH'(64'd29335);
      5'd16: r = Z_WIDTH'(64'd14668);
      5'd17: r = Z_WIDTH'(64'd7334);
      5'd18: r = Z_WIDTH'(64'd3667);
      5'd19: r = Z_WIDTH'(64'd1833);
      5'd20: r = Z_WIDTH'(64'd917);
      5'd21: r = Z_WIDTH'(64'd458);
      5'd22: r = Z_WIDTH'(64'd229);
      5'd23: r = Z_WIDTH'(64'd115);
      5'd24: r = Z_WIDTH'(64'd57);
      5'd25: r = Z_WIDTH'(64'd29);
      5'd26: r = Z_WIDTH'(64'd14);
      5'd27: r = Z_WIDTH'(64'd7);
      5'd28: r = Z_WIDTH'(64'd4);
      5'd29: r = Z_WIDTH'(64'd2);
      5'd30: r = Z_WIDTH'(64'd1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/c2p_prep.sv
// Input stage: forms the difference vector, folds the left half plane and seeds the angle.
`default_nettype none
module c2p_prep #(
  parameter int CW = 20,
  parameter int XW = 48
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [CW-1:0]                 origin_x_i,
  input  wire logic signed [CW-1:0]                 origin_y_i,
  input  wire logic signed [CW-1:0]                 point_x_i,
  input  wire logic signed [CW-1:0]                 point_y_i,
  output c2p_pkg::flags_t                           flags_o,
  output logic signed [XW-1:0]                      x_o,
  output logic signed [XW-1:0]                      y_o,
  output logic signed [c2p_pkg::Z_WIDTH-1:0]        z_o
);

  localparam int EXT = XW - CW - 1 - c2p_pkg::GUARD;

  logic signed [CW:0] dx, dy, xa, ya;
  logic               neg;
  c2p_pkg::flags_t    flags_d, flags_q;
  logic signed [XW-1:0] x_d, x_q, y_d, y_q;
  logic signed [c2p_pkg::Z_WIDTH-1:0] z_d, z_q;

  always_comb begin
    dx  = {point_x_i[CW-1], point_x_i} - {origin_x_i[CW-1], origin_x_i};
    dy  = {point_y_i[CW-1], point_y_i} - {origin_y_i[CW-1], origin_y_i};
    neg = dx[CW];
    // Mirror the left half plane into the right one.
    xa  = neg ? -dx : dx;
    ya  = neg ? -dy : dy;
    x_d = {{EXT{xa[CW]}}, xa, {c2p_pkg::GUARD{1'b0}}};
    y_d = {{EXT{ya[CW]}}, ya, {c2p_pkg::GUARD{1'b0}}};
    if (!neg) begin
      z_d = '0;
    end else if (dy[CW]) begin
      z_d = -c2p_pkg::HALF_Q24;
    end else begin
      z_d = c2p_pkg::HALF_Q24;
    end
    flags_d.valid  = start_i;
    flags_d.bypass = (dy == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign flags_o = flags_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule
`default_nettype wire

// File: design/c2p_cell.sv
// One vectoring CORDIC cell: a fixed-shift micro-rotation and its angle step, registered.
`default_nettype none
module c2p_cell #(
  parameter int XW    = 48,
  parameter int STAGE = 0
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire c2p_pkg::flags_t                      flags_i,
  input  wire logic signed [XW-1:0]                 x_i,
  input  wire logic signed [XW-1:0]                 y_i,
  input  wire logic signed [c2p_pkg::Z_WIDTH-1:0]   z_i,
  output c2p_pkg::flags_t                           flags_o,
  output logic signed [XW-1:0]                      x_o,
  output logic signed [XW-1:0]                      y_o,
  output logic signed [c2p_pkg::Z_WIDTH-1:0]        z_o
);

  localparam int SHIFT = STAGE % c2p_pkg::ATAN_ENTRIES;
  localparam logic signed [c2p_pkg::Z_WIDTH-1:0] ATAN =
    c2p_pkg::atan_q24(c2p_pkg::ATAN_IDX_W'(SHIFT));

  logic signed [XW-1:0] xs, ys, x_d, x_q, y_d, y_q;
  logic signed [c2p_pkg::Z_WIDTH-1:0] z_d, z_q;
  c2p_pkg::flags_t flags_q;

  always_comb begin
    xs = x_i >>> SHIFT;
    ys = y_i >>> SHIFT;
    if (flags_i.bypass) begin
      // Hold exact horizontal vectors untouched.
      x_d = x_i;
      y_d = y_i;
      z_d = z_i;
    end else if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else begin
      flags_q <= flags_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign flags_o = flags_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;

endmodule
`default_nettype wire

// File: design/c2p_post.sv
// Output stages: gain compensation, rounding and clamping of length and angle.
`default_nettype none
module c2p_post #(
  parameter int XW      = 48,
  parameter int DIST_W  = 21,
  parameter int ANGLE_W = 17,
  parameter int FRAC    = 8,
  parameter int STAGES  = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire c2p_pkg::flags_t                      flags_i,
  input  wire logic signed [XW-1:0]                 x_i,
  input  wire logic signed [c2p_pkg::Z_WIDTH-1:0]   z_i,
  output logic                                      done_o,
  output logic [DIST_W-1:0]                         distance_o,
  output logic signed [ANGLE_W-1:0]                 angle_o
);

  localparam int GUARD = c2p_pkg::GUARD;
  localparam int ZW    = c2p_pkg::Z_WIDTH;
  localparam int S     = c2p_pkg::ANGLE_FRAC - FRAC;
  localparam int ZRW   = ZW - S;
  localparam int HW    = XW - 1 - 32;
  localparam int PW    = HW + 33;
  localparam int DFW   = PW - GUARD;
  localparam logic [63:0] CORR   = (c2p_pkg::INV_GAIN * 64'd2) / 64'd3;
  localparam logic [63:0] GAIN64 = (STAGES >= 16) ? c2p_pkg::INV_GAIN
                                   : c2p_pkg::INV_GAIN + (CORR >> (2 * STAGES));
  localparam logic [31:0] GAIN   = GAIN64[31:0];
  localparam logic [DFW-1:0] DMAX = {{(DFW-DIST_W){1'b0}}, {DIST_W{1'b1}}};
  localparam logic signed [ZRW-1:0] HALF = ZRW'(64'(c2p_pkg::HALF_TURN) << FRAC);
  localparam logic signed [ZW-1:0] ROUND_Z = ZW'(64'd1 << (S - 1));
  localparam logic [PW-1:0] ROUND_D = PW'(64'd1 << (GUARD - 1));

  // stage 1
  logic [XW-2:0]        xc;
  logic signed [ZW-1:0] zsum;
  logic [63:0]          lo_d, lo_q;
  logic [HW+31:0]       hi_d, hi_q;
  logic [DIST_W-1:0]    byp1_q, byp2_q;
  logic signed [ZRW-1:0] zr_q;
  c2p_pkg::flags_t      f1_q, f2_q;
  // stage 2
  logic [PW-1:0]        psum;
  logic [DFW-1:0]       df_q;
  logic signed [ANGLE_W-1:0] ang_d, ang_q, ang3_q;
  // stage 3
  logic [DIST_W-1:0]    dist_d, dist_q;
  logic                 done_q;

  always_comb begin
    xc   = x_i[XW-1] ? '0 : x_i[XW-2:0];
    lo_d = 64'(xc[31:0]) * 64'(GAIN);
    hi_d = (HW+32)'(xc[XW-2:32]) * (HW+32)'(GAIN);
    zsum = z_i + ROUND_Z;
  end

  always_comb begin
    psum = PW'(hi_q) + PW'(lo_q[63:32]) + ROUND_D;
    if (zr_q > HALF) begin
      ang_d = ANGLE_W'(HALF);
    end else if (zr_q < -HALF) begin
      ang_d = ANGLE_W'(-HALF);
    end else begin
      ang_d = zr_q[ANGLE_W-1:0];
    end
  end

  always_comb begin
    if (f2_q.bypass) begin
      dist_d = byp2_q;
    end else if (df_q > DMAX) begin
      dist_d = DMAX[DIST_W-1:0];
    end else begin
      dist_d = df_q[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q   <= '0;
      f2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      f1_q   <= flags_i;
      f2_q   <= f1_q;
      done_q <= f2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    byp1_q <= x_i[GUARD +: DIST_W];
    zr_q   <= zsum[ZW-1:S];
    df_q   <= psum[PW-1:GUARD];
    byp2_q <= byp1_q;
    ang_q  <= ang_d;
    dist_q <= dist_d;
    ang3_q <= ang_q;
  end

  assign done_o     = done_q;
  assign distance_o = dist_q;
  assign angle_o    = ang3_q;

endmodule
`default_nettype wire

// File: design/cartesian_to_polar_degrees.sv
// Top level of the rectangular-to-polar converter: input stage, CORDIC cell chain, output stages.
// Throughput: one beat per cycle; busy_o stays low, so start_i may be high in every cycle.
// The depth is set by the chain of CORDIC_STAGES registered cells, one micro-rotation each,
// followed by a split 32-bit partial-product gain multiply over two stages.
// Reset (rst_ni, asynchronous, active low) clears the beat valid flags only; no clearing pass.
`default_nettype none
module cartesian_to_polar_degrees #(
  parameter int COORD_WIDTH   = 20,
  parameter int FRAC_BITS     = 8,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  output logic                                  busy_o,
  input  wire logic signed [COORD_WIDTH-1:0]    origin_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]    origin_y_i,
  input  wire logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  wire logic signed [COORD_WIDTH-1:0]    point_y_i,
  output logic                                  done_o,
  output logic [COORD_WIDTH:0]                  distance_o,
  output logic signed [FRAC_BITS+8:0]           angle_degrees_o
);

  // Difference width plus guard fraction plus headroom for CORDIC growth.
  localparam int XW = COORD_WIDTH + 1 + c2p_pkg::GUARD + 3;
  localparam int DIST_W  = COORD_WIDTH + 1;
  localparam int ANGLE_W = FRAC_BITS + 9;

  // Links between neighbors of the chain; entry 0 is the input stage.
  c2p_pkg::flags_t                    flags [CORDIC_STAGES+1];
  logic signed [XW-1:0]               xv    [CORDIC_STAGES+1];
  logic signed [XW-1:0]               yv    [CORDIC_STAGES+1];
  logic signed [c2p_pkg::Z_WIDTH-1:0] zv    [CORDIC_STAGES+1];

  // The pipeline never stalls and the receiver cannot push back.
  assign busy_o = 1'b0;

  // Form the difference, fold the left half plane, flag horizontal vectors.
  c2p_prep #(
    .CW (COORD_WIDTH),
    .XW (XW)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .origin_x_i (origin_x_i),
    .origin_y_i (origin_y_i),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .flags_o    (flags[0]),
    .x_o        (xv[0]),
    .y_o        (yv[0]),
    .z_o        (zv[0])
  );

  // Advance each beat by one micro-rotation per cell.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    c2p_cell #(
      .XW    (XW),
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .flags_i (flags[g]),
      .x_i     (xv[g]),
      .y_i     (yv[g]),
      .z_i     (zv[g]),
      .flags_o (flags[g+1]),
      .x_o     (xv[g+1]),
      .y_o     (yv[g+1]),
      .z_o     (zv[g+1])
    );
  end

  // Compensate the gain, round and clamp both results.
  c2p_post #(
    .XW      (XW),
    .DIST_W  (DIST_W),
    .ANGLE_W (ANGLE_W),
    .FRAC    (FRAC_BITS),
    .STAGES  (CORDIC_STAGES)
  ) u_post (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags[CORDIC_STAGES]),
    .x_i        (xv[CORDIC_STAGES]),
    .z_i        (zv[CORDIC_STAGES]),
    .done_o     (done_o),
    .distance_o (distance_o),
    .angle_o    (angle_degrees_o)
  );

endmodule
`default_nettype wire

// File: sim/tb_cartesian_to_polar_degrees.sv
// Self-checking testbench for the rectangular-to-polar converter: directed and random beats.
module tb_cartesian_to_polar_degrees;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W    = 20;
  localparam int FRAC_W     = 8;
  localparam int STAGES     = 16;
  localparam int DIST_W     = COORD_W + 1;
  localparam int ANG_W      = FRAC_W + 9;
  // Guard bits under the rotated coordinates and fraction bits of the angle sum.
  localparam int GUARD_W    = 24;
  localparam int ZFRAC_W    = 24;
  localparam longint HALF_TURN_DEG = 180;
  localparam int COORD_MIN  = -(1 << (COORD_W - 1));
  localparam int COORD_MAX  = (1 << (COORD_W - 1)) - 1;
  // Pipeline depth of the block, plus margin for the drain.
  localparam int LATENCY    = STAGES + 4;
  localparam int DRAIN_CYC  = LATENCY + 8;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_N   = 1130;
  localparam int REPORT_MAX = 10;

  // Inverse gain of the micro-rotation chain, unsigned Q32; short chains get a
  // small correction, long chains use the bare constant.
  localparam logic [63:0] INV_GAIN_Q32 = 64'd2608131496;
  localparam logic [63:0] GAIN_Q32 = (STAGES >= 16) ? INV_GAIN_Q32 :
    INV_GAIN_Q32 + (((INV_GAIN_Q32 * 64'd2) / 64'd3) >> (2 * STAGES));

  // atan(2^-k) in degrees with ZFRAC_W fraction bits.
  localparam longint ATAN_STEP_DEG [32] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7,
    4, 2, 1, 0
  };

  typedef struct {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
  } segment_t;

  typedef struct {
    logic [DIST_W-1:0]        distance;
    logic signed [ANG_W-1:0]  angle;
  } polar_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic signed [COORD_W-1:0] origin_x_i = '0;
  logic signed [COORD_W-1:0] origin_y_i = '0;
  logic signed [COORD_W-1:0] point_x_i  = '0;
  logic signed [COORD_W-1:0] point_y_i  = '0;
  logic                      busy_o;
  logic                      done_o;
  logic [DIST_W-1:0]         distance_o;
  logic signed [ANG_W-1:0]   angle_degrees_o;

  segment_t segments_to_send [$];
  segment_t segment_on_bus;
  polar_t   polar_expected [$];

  int  segments_total = 0;
  int  beats_taken    = 0;
  int  mismatch_cnt   = 0;
  int  stall_cycles   = 0;
  int  gap_left       = 0;
  int  burst_left     = 0;
  bit  beat_taken     = 1'b0;

  cartesian_to_polar_degrees #(
    .COORD_WIDTH   (COORD_W),
    .FRAC_BITS     (FRAC_W),
    .CORDIC_STAGES (STAGES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .done_o          (done_o),
    .distance_o      (distance_o),
    .angle_degrees_o (angle_degrees_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Vectoring CORDIC on the difference vector. Right shifts floor, the left
  // half plane is folded over first with the angle sum preset to +/-180, and
  // both outputs round half up before clamping.
  function automatic polar_t polar_of_segment(segment_t seg);
    longint dx, dy, x, y, z, xs, ys, ang, half;
    logic [63:0] ux, prod, len_v;
    int shift_z;
    polar_t r;
    dx = longint'(seg.point_x) - longint'(seg.origin_x);
    dy = longint'(seg.point_y) - longint'(seg.origin_y);
    half = HALF_TURN_DEG <<< FRAC_W;
    shift_z = ZFRAC_W - FRAC_W;
    if (dy == 0) begin
      // Horizontal vector: exact, no rotation needed.
      len_v = (dx < 0) ? 64'(-dx) : 64'(dx);
      ang   = (dx < 0) ? half : 0;
    end else begin
      x = dx;
      y = dy;
      z = 0;
      if (dx < 0) begin
        x = -dx;
        y = -dy;
        z = (dy > 0) ? (HALF_TURN_DEG <<< ZFRAC_W) : -(HALF_TURN_DEG <<< ZFRAC_W);
      end
      x = x <<< GUARD_W;
      y = y <<< GUARD_W;
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> (i % 32);
        ys = y >>> (i % 32);
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP_DEG[i % 32];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP_DEG[i % 32];
        end
      end
      if (x < 0) x = 0;
      // Split the Q32 gain multiply so nothing overflows 64 bits.
      ux    = 64'(x);
      prod  = (ux >> 32) * GAIN_Q32 + (((ux & 64'hFFFF_FFFF) * GAIN_Q32) >> 32);
      len_v = (prod + (64'd1 << (GUARD_W - 1))) >> GUARD_W;
      ang   = (z + (longint'(1) <<< (shift_z - 1))) >>> shift_z;
    end
    if (len_v > 64'((1 << DIST_W) - 1)) len_v = 64'((1 << DIST_W) - 1);
    if (ang > half)  ang = half;
    if (ang < -half) ang = -half;
    r.distance = len_v[DIST_W-1:0];
    r.angle    = ang[ANG_W-1:0];
    return r;
  endfunction

  task automatic queue_segment(int ox, int oy, int px, int py);
    segment_t seg;
    seg.origin_x = ox[COORD_W-1:0];
    seg.origin_y = oy[COORD_W-1:0];
    seg.point_x  = px[COORD_W-1:0];
    seg.point_y  = py[COORD_W-1:0];
    segments_to_send.push_back(seg);
    segments_total++;
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, (1 << COORD_W) - 1)) + COORD_MIN;
  endfunction

  // Pick an origin so that origin + delta stays inside the coordinate range.
  task automatic place_delta(int delta, output int o, output int p);
    int lo, hi;
    lo = (COORD_MIN - delta > COORD_MIN) ? COORD_MIN - delta : COORD_MIN;
    hi = (COORD_MAX - delta < COORD_MAX) ? COORD_MAX - delta : COORD_MAX;
    o = int'($urandom_range(0, hi - lo)) + lo;
    p = o + delta;
  endtask

  function automatic int corner_coord();
    case ($urandom_range(0, 4))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return 0;
      3: return -1;
      default: return rand_coord();
    endcase
  endfunction

  // Most gaps are short, a few long, and now and then a burst with none.
  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(30, 150);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_mismatch(string what, int expected_v, int actual_v);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_MAX)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, expected_v, actual_v);
  endtask

  // Stimulus: directed corners first, then a random mix of vector shapes.
  initial begin
    int ox, oy, px, py, dx, dy, pick;
    // Zero difference, both at the origin and far away from it.
    queue_segment(0, 0, 0, 0);
    queue_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    // Horizontal vectors: right, left, and the longest ones either way.
    queue_segment(0, 0, 256, 0);
    queue_segment(0, 0, -256, 0);
    queue_segment(COORD_MIN, 7, COORD_MAX, 7);
    queue_segment(COORD_MAX, -7, COORD_MIN, -7);
    // Vertical vectors: straight up and down, longest too.
    queue_segment(0, 0, 0, 256);
    queue_segment(0, 0, 0, -256);
    queue_segment(3, COORD_MIN, 3, COORD_MAX);
    queue_segment(-3, COORD_MAX, -3, COORD_MIN);
    // Diagonals into all four quadrants at full span.
    queue_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    queue_segment(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    queue_segment(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
    queue_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    // Left half plane just above and below the negative axis: near +/-180.
    queue_segment(COORD_MAX, 0, COORD_MIN, 1);
    queue_segment(COORD_MAX, 0, COORD_MIN, -1);
    queue_segment(0, 0, -1, 1);
    queue_segment(0, 0, -1, -1);
    // Right half plane one step off the axis, and unit steps.
    queue_segment(COORD_MIN, 0, COORD_MAX, 1);
    queue_segment(COORD_MIN, 0, COORD_MAX, -1);
    queue_segment(0, 0, 1, 1);
    queue_segment(-1, 1, 0, 0);

    for (int n = 0; n < RANDOM_N; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end else if (pick < 60) begin
        // Short vectors: rounding dominates the result.
        place_delta($urandom_range(0, 16) - 8, ox, px);
        place_delta($urandom_range(0, 16) - 8, oy, py);
        queue_segment(ox, oy, px, py);
      end else if (pick < 70) begin
        oy = rand_coord();
        queue_segment(rand_coord(), oy, rand_coord(), oy);
      end else if (pick < 77) begin
        ox = rand_coord();
        queue_segment(ox, rand_coord(), ox, rand_coord());
      end else if (pick < 87) begin
        queue_segment(corner_coord(), corner_coord(), corner_coord(), corner_coord());
      end else begin
        // Long x against a tiny y, or equal magnitudes: hug the axis or the diagonal.
        dx = int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
        dy = ($urandom_range(0, 1) == 1) ? ($urandom_range(0, 1) ? dx : -dx)
                                         : int'($urandom_range(0, 6)) - 3;
        place_delta(dx, ox, px);
        place_delta(dy, oy, py);
        queue_segment(ox, oy, px, py);
      end
    end

    // Hold reset, then release it on a falling edge.
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every beat is in and every result is out, then drain.
    while (beats_taken < segments_total || polar_expected.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (polar_expected.size() != 0)
      flag_mismatch("results still outstanding", 0, polar_expected.size());
    if (mismatch_cnt == 0) begin
      $display("cartesian_to_polar_degrees: match");
    end else begin
      $display("cartesian_to_polar_degrees: mismatch");
    end
    $finish;
  end

  // Driver: hold an offered beat until it is taken, then advance after a gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !beat_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (segments_to_send.size() != 0) begin
        segment_on_bus = segments_to_send.pop_front();
        origin_x_i <= segment_on_bus.origin_x;
        origin_y_i <= segment_on_bus.origin_y;
        point_x_i  <= segment_on_bus.point_x;
        point_y_i  <= segment_on_bus.point_y;
        start_i    <= 1'b1;
        gap_left   = next_gap();
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: predict each accepted beat, check each strobed result in order.
  always @(posedge clk_i) begin
    polar_t got, want;
    segment_t seg;
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        seg.origin_x = origin_x_i;
        seg.origin_y = origin_y_i;
        seg.point_x  = point_x_i;
        seg.point_y  = point_y_i;
        polar_expected.push_back(polar_of_segment(seg));
        beats_taken++;
        beat_taken = 1'b1;
      end
      if (done_o) begin
        got.distance = distance_o;
        got.angle    = angle_degrees_o;
        if (polar_expected.size() == 0) begin
          flag_mismatch("result with nothing expected, distance", 0, int'(got.distance));
        end else begin
          want = polar_expected.pop_front();
          if (got.distance !== want.distance)
            flag_mismatch("distance", int'(want.distance), int'(got.distance));
          if (got.angle !== want.angle)
            flag_mismatch("angle_degrees", int'(want.angle), int'(got.angle));
        end
      end
      // Watchdog: drop the run if nothing moves on either side for too long.
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("cartesian_to_polar_degrees: mismatch");
          $finish;
        end
      end
    end
  end

endmodule
